FILE: hdl/carp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_pkg - shared types and constants
// Field widths, register indexes, sequencer step codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package carp_pkg;

    // arithmetic word and field widths
    localparam int WORD_W   = 64;
    localparam int HALF_W   = 32;
    localparam int CB_W     = 32;
    localparam int RANK_W   = 16;
    localparam int COL_W    = 16;
    localparam int EB_W     = 5;
    localparam int TR_W     = 32;
    localparam int ROWS_W   = 32;
    localparam int PCOL_W   = 16;
    localparam int PB_W     = ROWS_W + PCOL_W + EB_W;
    localparam int RB_W     = COL_W + EB_W;
    localparam int OUT_W    = 48;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 32;
    localparam int IN_DATA_W  = ROWS_W + PCOL_W;
    localparam int OUT_DATA_W = 3 * OUT_W + COL_W;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_CHUNK_BYTES   = 3'd0;
    localparam logic [IDX_W-1:0] REG_NUM_RANKS     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MY_RANK       = 3'd2;
    localparam logic [IDX_W-1:0] REG_COLUMNS       = 3'd3;
    localparam logic [IDX_W-1:0] REG_ELEMENT_BYTES = 3'd4;
    localparam logic [IDX_W-1:0] REG_TOTAL_ROWS    = 3'd5;

    // configuration reset values
    localparam logic [CB_W-1:0]   CB_RESET   = 32'd1048576;
    localparam logic [RANK_W-1:0] NR_RESET   = 16'd1;
    localparam logic [RANK_W-1:0] RANK_RESET = 16'd0;
    localparam logic [COL_W-1:0]  COLS_RESET = 16'd1;
    localparam logic [EB_W-1:0]   EB_RESET   = 5'd4;
    localparam logic [TR_W-1:0]   TR_RESET   = 32'd1;

    // sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE      = 5'd0;
    localparam logic [STEP_W-1:0] ST_MUL_PC    = 5'd1;
    localparam logic [STEP_W-1:0] ST_MUL_PB    = 5'd2;
    localparam logic [STEP_W-1:0] ST_SPAN      = 5'd3;
    localparam logic [STEP_W-1:0] ST_DIV_SPAN  = 5'd4;
    localparam logic [STEP_W-1:0] ST_DIV_RANK  = 5'd5;
    localparam logic [STEP_W-1:0] ST_DIV_ALN   = 5'd6;
    localparam logic [STEP_W-1:0] ST_MUL_EVEN  = 5'd7;
    localparam logic [STEP_W-1:0] ST_MUL_FB    = 5'd8;
    localparam logic [STEP_W-1:0] ST_MUL_LEN   = 5'd9;
    localparam logic [STEP_W-1:0] ST_TRIM_HEAD = 5'd10;
    localparam logic [STEP_W-1:0] ST_TRIM_TAIL = 5'd11;
    localparam logic [STEP_W-1:0] ST_DIV_WOFF  = 5'd12;
    localparam logic [STEP_W-1:0] ST_DIV_WCNT  = 5'd13;
    localparam logic [STEP_W-1:0] ST_DIV_CUR   = 5'd14;
    localparam logic [STEP_W-1:0] ST_ADV       = 5'd15;
    localparam logic [STEP_W-1:0] ST_DIV_NEW   = 5'd16;
    localparam logic [STEP_W-1:0] ST_DONE      = 5'd17;

    // controller to datapath
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              fire;
    } carp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic unit_done;
        logic skip;
        logic cb_zero;
        logic mine_zero;
        logic out_busy;
    } carp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/carp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_mul - sequential 64 x 32 multiplier, product modulo 2^64
// One 32 x 32 multiplier is used for the low and the high half of the
// wide operand; the partial products are summed in the PH_SUM phase.
// ----------------------------------------------------------------------------
module carp_mul
    import carp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [HALF_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] prod
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;

    logic [1:0]        ph_reg;
    logic [1:0]        ph_next;
    logic              done_reg;
    logic [HALF_W-1:0] ahi_reg;
    logic [HALF_W-1:0] b_reg;
    logic [WORD_W-1:0] p_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] mul_p;

    // share the multiplier between both halves
    assign mul_a = (ph_reg == PH_IDLE) ? a[HALF_W-1:0] : ahi_reg;
    assign mul_b = (ph_reg == PH_IDLE) ? b : b_reg;
    assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

    // advance the phase
    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    ph_next = PH_HI;
                end
            end
            PH_HI:   ph_next = PH_SUM;
            PH_SUM:  ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= (ph_reg == PH_SUM);
        end
    end

    // capture partial products and sum them
    always_ff @(posedge clk)
    begin
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    p_reg   <= mul_p;
                    ahi_reg <= a[WORD_W-1:HALF_W];
                    b_reg   <= b;
                end
            end
            PH_HI:
            begin
                acc_reg <= p_reg;
                p_reg   <= mul_p;
            end
            PH_SUM:
            begin
                acc_reg <= acc_reg + {p_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

FILE: hdl/carp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_div - iterative 64 / 32 unsigned divider
// Restoring division, two quotient bits per cycle. A zero divisor yields a
// zero quotient.
// ----------------------------------------------------------------------------
module carp_div
    import carp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [HALF_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient,
    output logic [HALF_W-1:0] remainder
);

    localparam int ITER  = WORD_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] q_reg;
    logic [HALF_W-1:0] rem_reg;
    logic [HALF_W-1:0] d_reg;
    logic              dz_reg;
    logic [HALF_W:0]   s1;
    logic [HALF_W:0]   s2;

    // one restoring step: {quotient bit, new partial remainder}
    function automatic logic [HALF_W:0] div_step(input logic [HALF_W-1:0] rem,
                                                 input logic              din,
                                                 input logic [HALF_W-1:0] d);
        logic [HALF_W:0] t;
        logic [HALF_W:0] diff;
        begin
            t    = {rem, din};
            diff = t - {1'b0, d};
            if (t >= {1'b0, d})
            begin
                return {1'b1, diff[HALF_W-1:0]};
            end
            else
            begin
                return {1'b0, t[HALF_W-1:0]};
            end
        end
    endfunction

    assign s1 = div_step(rem_reg, q_reg[WORD_W-1], d_reg);
    assign s2 = div_step(s1[HALF_W-1:0], q_reg[WORD_W-2], d_reg);

    // sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ITER - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift dividend bits into the remainder, quotient bits in behind
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
            dz_reg  <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[WORD_W-3:0], s1[HALF_W], s2[HALF_W]};
            rem_reg <= s2[HALF_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dz_reg ? '0 : q_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

FILE: hdl/carp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_dp - partitioner datapath
// Configuration registers, running byte positions, work registers, the
// shared multiplier and divider, and the output word register.
// ----------------------------------------------------------------------------
module carp_dp
    import carp_pkg::*;
#(
    parameter int POS_W = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [IDX_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  carp_cmd_t             cmd,
    output carp_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    // configuration
    logic [CB_W-1:0]   cb_reg;
    logic [RANK_W-1:0] nr_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [COL_W-1:0]  cols_reg;
    logic [EB_W-1:0]   eb_reg;
    logic [TR_W-1:0]   tr_reg;

    // running positions
    logic [POS_W-1:0]  cur_reg;
    logic [POS_W-1:0]  aln_reg;

    // work registers
    logic [ROWS_W-1:0] rows_reg;
    logic [PCOL_W-1:0] pcols_reg;
    logic [PB_W-1:0]   pb_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] end_reg;
    logic [WORD_W-1:0] nch_reg;
    logic [WORD_W-1:0] even_reg;
    logic [RANK_W-1:0] extra_reg;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] off_reg;
    logic [WORD_W-1:0] len_reg;
    logic [OUT_W-1:0]  woff_reg;
    logic [OUT_W-1:0]  wcnt_reg;
    logic [COL_W-1:0]  wcols_reg;
    logic [OUT_W-1:0]  roff_reg;
    logic              stat_reg;

    // output word
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    // derived values
    logic [WORD_W-1:0] cur_w;
    logic [WORD_W-1:0] aln_w;
    logic [RANK_W-1:0] ranks_w;
    logic [RB_W-1:0]   rb_w;
    logic              gets_extra;
    logic [WORD_W-1:0] mine_w;
    logic [WORD_W-1:0] tail_w;
    logic              cb_zero;

    // unit hookup
    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic              mul_done;
    logic [WORD_W-1:0] mul_prod;
    logic              div_start;
    logic [WORD_W-1:0] div_a;
    logic [HALF_W-1:0] div_b;
    logic              div_done;
    logic [WORD_W-1:0] div_q;
    logic [HALF_W-1:0] div_r;

    assign cur_w      = WORD_W'(cur_reg);
    assign aln_w      = WORD_W'(aln_reg);
    assign ranks_w    = (nr_reg == '0) ? RANK_W'(1) : nr_reg;
    assign rb_w       = RB_W'(cols_reg) * RB_W'(eb_reg);
    assign gets_extra = (extra_reg > rank_reg);
    assign mine_w     = even_reg + WORD_W'(gets_extra);
    assign tail_w     = off_reg + len_reg;
    assign cb_zero    = (cb_reg == '0);

    // select multiplier operands
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (cmd.step)
            ST_MUL_PC:
            begin
                mul_start = cmd.fire;
                mul_a     = WORD_W'(rows_reg);
                mul_b     = HALF_W'(pcols_reg);
            end
            ST_MUL_PB:
            begin
                mul_start = cmd.fire;
                mul_a     = WORD_W'(pb_reg);
                mul_b     = HALF_W'(eb_reg);
            end
            ST_MUL_EVEN:
            begin
                mul_start = cmd.fire;
                mul_a     = even_reg;
                mul_b     = HALF_W'(rank_reg);
            end
            ST_MUL_FB:
            begin
                mul_start = cmd.fire;
                mul_a     = first_reg;
                mul_b     = cb_reg;
            end
            ST_MUL_LEN:
            begin
                mul_start = cmd.fire;
                mul_a     = mine_w;
                mul_b     = cb_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // select divider operands
    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (cmd.step)
            ST_DIV_SPAN:
            begin
                div_start = cmd.fire;
                div_a     = span_reg;
                div_b     = cb_reg;
            end
            ST_DIV_RANK:
            begin
                div_start = cmd.fire;
                div_a     = nch_reg;
                div_b     = HALF_W'(ranks_w);
            end
            ST_DIV_ALN:
            begin
                div_start = cmd.fire;
                div_a     = aln_w;
                div_b     = cb_reg;
            end
            ST_DIV_WOFF:
            begin
                div_start = cmd.fire;
                div_a     = off_reg;
                div_b     = HALF_W'(rb_w);
            end
            ST_DIV_WCNT:
            begin
                div_start = cmd.fire;
                div_a     = len_reg;
                div_b     = HALF_W'(rb_w);
            end
            ST_DIV_CUR:
            begin
                div_start = cmd.fire;
                div_a     = cur_w;
                div_b     = HALF_W'(rb_w);
            end
            ST_DIV_NEW:
            begin
                div_start = cmd.fire;
                div_a     = cur_w;
                div_b     = cb_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    carp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    carp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // configuration, positions and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_reg        <= CB_RESET;
            nr_reg        <= NR_RESET;
            rank_reg      <= RANK_RESET;
            cols_reg      <= COLS_RESET;
            eb_reg        <= EB_RESET;
            tr_reg        <= TR_RESET;
            cur_reg       <= '0;
            aln_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_CHUNK_BYTES:   cb_reg   <= cfg_data[CB_W-1:0];
                    REG_NUM_RANKS:     nr_reg   <= cfg_data[RANK_W-1:0];
                    REG_MY_RANK:       rank_reg <= cfg_data[RANK_W-1:0];
                    REG_COLUMNS:       cols_reg <= cfg_data[COL_W-1:0];
                    REG_ELEMENT_BYTES: eb_reg   <= cfg_data[EB_W-1:0];
                    REG_TOTAL_ROWS:    tr_reg   <= cfg_data[TR_W-1:0];
                    default:           cb_reg   <= cb_reg;
                endcase
            end

            // clear positions on a fresh dataset, advance after the piece
            if (cmd.fire && cmd.step == ST_IDLE && s_tuser)
            begin
                cur_reg <= '0;
                aln_reg <= '0;
            end
            if (cmd.fire && cmd.step == ST_ADV)
            begin
                cur_reg <= end_reg[POS_W-1:0];
                if (cb_zero)
                begin
                    aln_reg <= end_reg[POS_W-1:0];
                end
            end
            if (div_done && cmd.step == ST_DIV_NEW)
            begin
                aln_reg <= cur_reg - POS_W'(div_r);
            end

            // hold the word until taken
            if (cmd.fire && cmd.step == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        case (cmd.step)
            ST_IDLE:
            begin
                if (cmd.fire)
                begin
                    rows_reg  <= s_tdata[ROWS_W-1:0];
                    pcols_reg <= s_tdata[IN_DATA_W-1:ROWS_W];
                    woff_reg  <= '0;
                    wcnt_reg  <= '0;
                    wcols_reg <= '0;
                    roff_reg  <= '0;
                    stat_reg  <= 1'b0;
                end
            end
            ST_MUL_PC, ST_MUL_PB:
            begin
                if (mul_done)
                begin
                    pb_reg <= mul_prod[PB_W-1:0];
                end
            end
            ST_SPAN:
            begin
                if (cmd.fire)
                begin
                    span_reg <= WORD_W'(pb_reg) + (cur_w - aln_w);
                    end_reg  <= cur_w + WORD_W'(pb_reg);
                    stat_reg <= (tr_reg != '0) && cb_zero;
                end
            end
            ST_DIV_SPAN:
            begin
                if (div_done)
                begin
                    nch_reg <= div_q + WORD_W'(div_r != '0);
                end
            end
            ST_DIV_RANK:
            begin
                if (div_done)
                begin
                    even_reg  <= div_q;
                    extra_reg <= div_r[RANK_W-1:0];
                end
            end
            ST_DIV_ALN:
            begin
                if (div_done)
                begin
                    first_reg <= div_q;
                end
            end
            ST_MUL_EVEN:
            begin
                if (mul_done)
                begin
                    first_reg <= first_reg + mul_prod
                                 + WORD_W'(gets_extra ? rank_reg : extra_reg);
                end
            end
            ST_MUL_FB:
            begin
                if (mul_done)
                begin
                    off_reg <= (cur_w > mul_prod) ? cur_w : mul_prod;
                end
            end
            ST_MUL_LEN:
            begin
                if (mul_done)
                begin
                    len_reg   <= mul_prod;
                    wcols_reg <= cols_reg;
                end
            end
            ST_TRIM_HEAD:
            begin
                // a share that starts at the append point skips the bytes
                // already written in its first chunk
                if (cmd.fire && off_reg == cur_w)
                begin
                    len_reg <= len_reg - (cur_w - aln_w);
                end
            end
            ST_TRIM_TAIL:
            begin
                // clip the share at the end of the piece
                if (cmd.fire && tail_w > end_reg)
                begin
                    len_reg <= end_reg - off_reg;
                end
            end
            ST_DIV_WOFF:
            begin
                if (div_done)
                begin
                    woff_reg <= div_q[OUT_W-1:0];
                end
            end
            ST_DIV_WCNT:
            begin
                if (div_done)
                begin
                    wcnt_reg <= div_q[OUT_W-1:0];
                end
            end
            ST_DIV_CUR:
            begin
                if (div_done)
                begin
                    roff_reg <= woff_reg - div_q[OUT_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (cmd.fire)
                begin
                    out_data_reg <= {roff_reg, wcols_reg, wcnt_reg, woff_reg};
                    out_user_reg <= stat_reg;
                end
            end
            default:
            begin
                stat_reg <= stat_reg;
            end
        endcase
    end

    // status to the controller
    assign sts.unit_done = mul_done | div_done;
    assign sts.skip      = (tr_reg == '0) || cb_zero;
    assign sts.cb_zero   = cb_zero;
    assign sts.mine_zero = (mine_w == '0);
    assign sts.out_busy  = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
`default_nettype wire

FILE: hdl/carp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_ctrl - partitioner sequencer
// Steps one piece through the multiply, divide and adjust operations and
// waits on the shared units between them.
// ----------------------------------------------------------------------------
module carp_ctrl
    import carp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  carp_sts_t sts,
    output carp_cmd_t cmd
);

    logic [STEP_W-1:0] state_reg;
    logic [STEP_W-1:0] state_next;
    logic              wait_reg;
    logic              wait_next;
    logic              fire;

    // step that follows a multiply or divide step
    function automatic logic [STEP_W-1:0] unit_follow(input logic [STEP_W-1:0] st,
                                                      input logic mine_zero);
        logic [STEP_W-1:0] nx;
        begin
            case (st)
                ST_MUL_PC:   nx = ST_MUL_PB;
                ST_MUL_PB:   nx = ST_SPAN;
                ST_DIV_SPAN: nx = ST_DIV_RANK;
                ST_DIV_RANK: nx = ST_DIV_ALN;
                ST_DIV_ALN:  nx = mine_zero ? ST_ADV : ST_MUL_EVEN;
                ST_MUL_EVEN: nx = ST_MUL_FB;
                ST_MUL_FB:   nx = ST_MUL_LEN;
                ST_MUL_LEN:  nx = ST_TRIM_HEAD;
                ST_DIV_WOFF: nx = ST_DIV_WCNT;
                ST_DIV_WCNT: nx = ST_DIV_CUR;
                ST_DIV_CUR:  nx = ST_ADV;
                ST_DIV_NEW:  nx = ST_DONE;
                default:     nx = ST_IDLE;
            endcase
            return nx;
        end
    endfunction

    // next step and command
    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        fire       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    fire       = 1'b1;
                    state_next = ST_MUL_PC;
                end
            end
            ST_SPAN:
            begin
                fire       = 1'b1;
                state_next = sts.skip ? ST_ADV : ST_DIV_SPAN;
            end
            ST_TRIM_HEAD:
            begin
                fire       = 1'b1;
                state_next = ST_TRIM_TAIL;
            end
            ST_TRIM_TAIL:
            begin
                fire       = 1'b1;
                state_next = ST_DIV_WOFF;
            end
            ST_ADV:
            begin
                fire       = 1'b1;
                state_next = sts.cb_zero ? ST_DONE : ST_DIV_NEW;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_PC, ST_MUL_PB, ST_DIV_SPAN, ST_DIV_RANK, ST_DIV_ALN,
            ST_MUL_EVEN, ST_MUL_FB, ST_MUL_LEN, ST_DIV_WOFF, ST_DIV_WCNT,
            ST_DIV_CUR, ST_DIV_NEW:
            begin
                // start the unit once, then wait for its result
                if (!wait_reg)
                begin
                    fire      = 1'b1;
                    wait_next = 1'b1;
                end
                else if (sts.unit_done)
                begin
                    wait_next  = 1'b0;
                    state_next = unit_follow(state_reg, sts.mine_zero);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd.step = state_reg;
    assign cmd.fire = fire;

endmodule
`default_nettype wire

FILE: hdl/chunk_aligned_rank_partitioner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chunk_aligned_rank_partitioner - share of chunk-aligned output rows
// Per input piece, computes this rank's write window in the output dataset
// and the first row to read inside the piece.
//
//   channel | direction | tdata / data                        | tuser
//   s_*     | in        | piece_rows, piece_columns           | new_dataset
//   m_*     | out       | write_row_offset, write_row_count,  | status
//           |           | write_columns, read_row_offset      |
//   cfg_*   | in        | cfg_addr register index, cfg_data   | -
//
// One piece at a time. Multiplies and 64/32 divisions run in the shared
// units (two quotient bits per cycle in the divider), and the sequencer
// waits for each result before the next step. s_tready is high only
// between pieces; a finished word waits in the output register while the
// next piece is taken. Reset needs no sweep.
// ----------------------------------------------------------------------------
module chunk_aligned_rank_partitioner
    import carp_pkg::*;
#(
    parameter int POS_WIDTH = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // piece in: tdata = piece_rows[31:0], piece_columns[47:32]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser = new_dataset
    input  logic                  s_tuser,
    // result out: tdata = write_row_offset[47:0], write_row_count[95:48],
    // write_columns[111:96], read_row_offset[159:112]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tuser = status
    output logic                  m_tuser,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]      cfg_data
);

    carp_cmd_t cmd;
    carp_sts_t sts;

    assign cfg_ready = 1'b1;

    carp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    carp_dp #(
        .POS_W (POS_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: hdl/carp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// carp_checker - port-level checks for the partitioner
// Output word hold under stall, empty-result consistency and the one piece
// at a time input side.
// ----------------------------------------------------------------------------
module carp_checker
    import carp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // an invalid chunk size gives an all-zero word
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid chunk size with nonzero result");

    // no columns means no rows and no offsets
    a_cols_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[111:96] == '0 |->
        m_tdata[47:0] == '0 && m_tdata[95:48] == '0 && m_tdata[159:112] == '0)
        else $error("empty share with nonzero rows or offsets");

    // busy right after a piece is taken
    a_one_piece: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second piece taken while busy");

endmodule

bind chunk_aligned_rank_partitioner carp_checker u_carp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
